// ----- hw/rtl/fbc_pkg.sv -----
// Frustum box cull: shared constants and code types.
// No dependencies; imported by frustum_box_cull_core.
package fbc_pkg;

    // Default widths of the box coordinates
    localparam int COORD_WIDTH_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 8;

    // Matrix elements are signed Q7.8; coefficients need one bit more
    localparam int MAT_W       = 16;
    localparam int COEF_W      = MAT_W + 1;
    localparam int MAT_ROWS    = 4;
    localparam int MAT_COLS    = 4;
    localparam int AXES        = 3;
    localparam int PLANE_COUNT = 6;

    // Register file: four 64-bit columns at 8-byte spacing
    localparam int REG_W  = 64;
    localparam int ADDR_W = 5;

    // 1.0 on the diagonal of the reset matrix
    localparam logic [MAT_W-1:0] IDENT_DIAG = 16'd256;

    typedef enum logic [1:0] {
        REG_VP_COL0 = 2'd0,
        REG_VP_COL1 = 2'd1,
        REG_VP_COL2 = 2'd2,
        REG_VP_COL3 = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        PLANE_LEFT   = 3'd0,
        PLANE_RIGHT  = 3'd1,
        PLANE_BOTTOM = 3'd2,
        PLANE_TOP    = 3'd3,
        PLANE_NEAR   = 3'd4,
        PLANE_FAR    = 3'd5,
        PLANE_NONE   = 3'd6
    } plane_t;

endpackage

// ----- hw/rtl/frustum_box_cull_core.sv -----
// Frustum box cull core: positive-vertex test of boxes against six clip planes.
// Throughput one box per cycle while the output register is not held by m_ready low.
// Planes are rebuilt from the matrix registers every cycle (one register stage).
// Reset (aresetn low, synchronous): pipeline emptied, matrix set to identity.
// Output register holds a result while m_ready is low; bubbles still fill behind it.
// Depends on fbc_pkg.
module frustum_box_cull_core #(
    parameter int COORD_WIDTH   = fbc_pkg::COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = fbc_pkg::FRACTION_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Input words: one box per word
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [COORD_WIDTH-1:0]     s_box_min_x,
    input  logic signed [COORD_WIDTH-1:0]     s_box_min_y,
    input  logic signed [COORD_WIDTH-1:0]     s_box_min_z,
    input  logic signed [COORD_WIDTH-1:0]     s_box_max_x,
    input  logic signed [COORD_WIDTH-1:0]     s_box_max_y,
    input  logic signed [COORD_WIDTH-1:0]     s_box_max_z,

    // Result words
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_visible,
    output logic [2:0]                        m_first_failing_plane,

    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fbc_pkg::ADDR_W-1:0]        paddr,
    input  logic [fbc_pkg::REG_W-1:0]         pwdata,
    output logic [fbc_pkg::REG_W-1:0]         prdata,
    output logic                              pready
);
    import fbc_pkg::*;

    // Exact widths: product coef*coord, scaled constant term, and the full sum
    localparam int PROD_W = COEF_W + COORD_WIDTH;
    localparam int D_W    = COEF_W + FRACTION_BITS;
    localparam int SUM_W  = ((PROD_W > D_W) ? PROD_W : D_W) + 2;

    // ------------------------------------------------------------------
    // Matrix registers (APB, 8-byte spacing, index from paddr[4:3])
    // ------------------------------------------------------------------
    logic [REG_W-1:0] vp_col_reg [MAT_COLS];
    reg_idx_t         cfg_idx;
    logic             cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[4:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = vp_col_reg[paddr[4:3]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < MAT_COLS; c++) begin
                vp_col_reg[c] <= REG_W'(IDENT_DIAG) << (MAT_W * c);
            end
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_VP_COL0: vp_col_reg[0] <= pwdata;
                REG_VP_COL1: vp_col_reg[1] <= pwdata;
                REG_VP_COL2: vp_col_reg[2] <= pwdata;
                REG_VP_COL3: vp_col_reg[3] <= pwdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Plane coefficients, rebuilt each cycle from the matrix into plane_reg.
    // The user must change config only when idle; the block does not enforce it.
    // Then the plane_reg lag is never seen: a box accepted after a write meets the new planes.
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0] plane_reg  [PLANE_COUNT][MAT_COLS];
    logic signed [COEF_W-1:0] plane_next [PLANE_COUNT][MAT_COLS];

    always_comb begin
        logic signed [COEF_W-1:0] r0, r1, r2, r3;
        for (int c = 0; c < MAT_COLS; c++) begin
            r0 = COEF_W'($signed(vp_col_reg[c][0*MAT_W +: MAT_W]));
            r1 = COEF_W'($signed(vp_col_reg[c][1*MAT_W +: MAT_W]));
            r2 = COEF_W'($signed(vp_col_reg[c][2*MAT_W +: MAT_W]));
            r3 = COEF_W'($signed(vp_col_reg[c][3*MAT_W +: MAT_W]));
            plane_next[PLANE_LEFT][c]   = r3 + r0;
            plane_next[PLANE_RIGHT][c]  = r3 - r0;
            plane_next[PLANE_BOTTOM][c] = r3 + r1;
            plane_next[PLANE_TOP][c]    = r3 - r1;
            plane_next[PLANE_NEAR][c]   = r2;
            plane_next[PLANE_FAR][c]    = r3 - r2;
        end
    end

    always_ff @(posedge aclk) begin
        plane_reg <= plane_next;
    end

    // ------------------------------------------------------------------
    // Pipeline control: each stage moves when its successor has room
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic en1, en2, en3, en_out;

    assign en_out  = !m_valid_reg || m_ready;
    assign en3     = !v3_reg || en_out;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1)    v1_reg      <= s_valid;
            if (en2)    v2_reg      <= v1_reg;
            if (en3)    v3_reg      <= v2_reg;
            if (en_out) m_valid_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the box corners
    // ------------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] lo_reg [AXES];
    logic signed [COORD_WIDTH-1:0] hi_reg [AXES];

    always_ff @(posedge aclk) begin
        if (en1) begin
            lo_reg[0] <= s_box_min_x;
            lo_reg[1] <= s_box_min_y;
            lo_reg[2] <= s_box_min_z;
            hi_reg[0] <= s_box_max_x;
            hi_reg[1] <= s_box_max_y;
            hi_reg[2] <= s_box_max_z;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: positive-vertex select and the 18 products, plus scaled d
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] prod_reg  [PLANE_COUNT][AXES];
    logic signed [PROD_W-1:0] prod_next [PLANE_COUNT][AXES];
    logic signed [D_W-1:0]    dterm_reg  [PLANE_COUNT];
    logic signed [D_W-1:0]    dterm_next [PLANE_COUNT];

    always_comb begin
        logic signed [COEF_W-1:0]      coef;
        logic signed [COORD_WIDTH-1:0] corner;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            for (int a = 0; a < AXES; a++) begin
                coef   = plane_reg[p][a];
                // zero coefficient takes the min corner; product is zero anyway
                corner = (coef > 0) ? hi_reg[a] : lo_reg[a];
                prod_next[p][a] = PROD_W'(coef) * PROD_W'(corner);
            end
            dterm_next[p] = D_W'(plane_reg[p][MAT_COLS-1]) <<< FRACTION_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            prod_reg  <= prod_next;
            dterm_reg <= dterm_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: pairwise partial sums
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] psum_a_reg [PLANE_COUNT];
    logic signed [SUM_W-1:0] psum_b_reg [PLANE_COUNT];

    always_ff @(posedge aclk) begin
        if (en3) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                psum_a_reg[p] <= SUM_W'(prod_reg[p][0]) + SUM_W'(prod_reg[p][1]);
                psum_b_reg[p] <= SUM_W'(prod_reg[p][2]) + SUM_W'(dterm_reg[p]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: final sum, sign test, first rejecting plane
    // ------------------------------------------------------------------
    logic [PLANE_COUNT-1:0]  neg;
    plane_t                  fail_next;
    plane_t                  fail_reg;

    always_comb begin
        logic signed [SUM_W-1:0] total;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            total  = psum_a_reg[p] + psum_b_reg[p];
            neg[p] = total[SUM_W-1];
        end
        // lowest-numbered negative plane wins; zero counts as touching
        fail_next = PLANE_NONE;
        for (int p = PLANE_COUNT - 1; p >= 0; p--) begin
            if (neg[p]) begin
                fail_next = plane_t'(3'(p));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            fail_reg <= fail_next;
        end
    end

    assign m_first_failing_plane = fail_reg;
    assign m_visible             = (fail_reg == PLANE_NONE);

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_flag_matches_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_visible == (m_first_failing_plane == PLANE_NONE)))
        else $error("visible flag disagrees with plane code");

    a_code_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_first_failing_plane <= PLANE_NONE))
        else $error("plane code out of range");

    a_accept_fills_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted word lost at stage 1");

    a_no_drop_s3: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !en3) |=> v3_reg)
        else $error("stalled stage 3 word dropped");

    a_reset_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> (vp_col_reg[0] == REG_W'(IDENT_DIAG)
                             && vp_col_reg[3] == (REG_W'(IDENT_DIAG) << (3 * MAT_W))))
        else $error("matrix not identity after reset");

endmodule
